@@ sv/note_string_sequencer_assert.svh @@
`ifndef NOTE_STRING_SEQUENCER_ASSERT_SVH
`define NOTE_STRING_SEQUENCER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define NSS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("note_string_sequencer check failed");

// next-cycle implication, checked outside reset
`define NSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("note_string_sequencer check failed");

`endif

@@ sv/nss_pkg.sv @@
package nss_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SHARP = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CASE_OFS = 8'h20;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_R     = 8'h72;

  localparam logic [3:0] IDX_C = 4'd0;
  localparam logic [3:0] IDX_D = 4'd2;
  localparam logic [3:0] IDX_E = 4'd4;
  localparam logic [3:0] IDX_F = 4'd5;
  localparam logic [3:0] IDX_G = 4'd7;
  localparam logic [3:0] IDX_A = 4'd9;
  localparam logic [3:0] IDX_B = 4'd11;

  localparam logic [5:0] NUM_MAX     = 6'd63;
  localparam logic [5:0] LEN_RESET   = 6'd4;
  localparam logic [5:0] LEN_WRAP    = 6'd1;
  localparam logic [2:0] OCT_RESET   = 3'd1;
  localparam logic [2:0] OCT_MAX     = 3'd4;
  localparam logic [5:0] LEN_NUM_MAX = 6'd32;

  typedef enum logic [5:0] {
    MODE_IDLE   = 6'b000001,
    MODE_LETTER = 6'b000010,
    MODE_NOTE   = 6'b000100,
    MODE_REST   = 6'b001000,
    MODE_OCT    = 6'b010000,
    MODE_SKIP   = 6'b100000
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EV   = 3'b010,
    ST_WRAP = 3'b100
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic show_wrap;
  } nss_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ev_now;
    logic nul_now;
    logic wrap_pend;
  } nss_status_t;

  function automatic logic [8:0] pitch_of(input logic [3:0] idx);
    logic [8:0] p;
    begin
      unique case (idx)
        4'd0:    p = 9'd262;
        4'd1:    p = 9'd278;
        4'd2:    p = 9'd294;
        4'd3:    p = 9'd312;
        4'd4:    p = 9'd330;
        4'd5:    p = 9'd349;
        4'd6:    p = 9'd371;
        4'd7:    p = 9'd392;
        4'd8:    p = 9'd416;
        4'd9:    p = 9'd440;
        4'd10:   p = 9'd468;
        default: p = 9'd494;
      endcase
      return p;
    end
  endfunction

  // 32 / n for n in 1..32
  function automatic logic [5:0] len_of(input logic [5:0] n);
    logic [5:0] q;
    begin
      if (n == 6'd1)       q = 6'd32;
      else if (n == 6'd2)  q = 6'd16;
      else if (n == 6'd3)  q = 6'd10;
      else if (n == 6'd4)  q = 6'd8;
      else if (n == 6'd5)  q = 6'd6;
      else if (n == 6'd6)  q = 6'd5;
      else if (n <= 6'd8)  q = 6'd4;
      else if (n <= 6'd10) q = 6'd3;
      else if (n <= 6'd16) q = 6'd2;
      else                 q = 6'd1;
      return q;
    end
  endfunction

endpackage

@@ sv/note_string_sequencer.sv @@
// Music macro language player: song text enters one character per item on
// song_char, and every note or rest token that ends at a space or NUL leaves
// as one result (tone_hz, length_ticks, silent); a NUL adds a silent one-tick
// wrap result and restores octave 1 and length 1. A character with results (one
// or two) holds the next character back, because the controller holds one
// character at a time and char_ready is low until its last result is taken,
// also while note_ready is low. All token decode, the 32/n length lookup and
// the pitch table work in the cycle that accepts the character.
module note_string_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_ready,
  input  logic [7:0]  song_char,
  output logic        note_valid,
  input  logic        note_ready,
  output logic [11:0] tone_hz,
  output logic [5:0]  length_ticks,
  output logic        silent,
  output logic        song_wrapped,
  output logic        last_of_run
);
  import nss_pkg::*;

  nss_cmd_t    cmd;
  nss_status_t status;

  nss_controller u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .note_valid  (note_valid),
    .note_ready  (note_ready),
    .last_of_run (last_of_run),
    .status      (status),
    .cmd         (cmd)
  );

  nss_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .song_char    (song_char),
    .cmd          (cmd),
    .status       (status),
    .tone_hz      (tone_hz),
    .length_ticks (length_ticks),
    .silent       (silent),
    .song_wrapped (song_wrapped)
  );

endmodule

@@ sv/nss_datapath.sv @@
module nss_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          song_char,
  input  nss_pkg::nss_cmd_t   cmd,
  output nss_pkg::nss_status_t status,
  output logic [11:0]         tone_hz,
  output logic [5:0]          length_ticks,
  output logic                silent,
  output logic                song_wrapped
);
  import nss_pkg::*;

  mode_t       mode, mode_next;
  logic [3:0]  note_idx, note_idx_next;
  logic [5:0]  num, num_next;
  logic        seen, seen_next;
  logic        closed, closed_next;
  logic [2:0]  oct, oct_next;
  logic [5:0]  len, len_next;

  logic [11:0] ev_tone;
  logic [5:0]  ev_len;
  logic        ev_sil;
  logic        wrap_pend;

  logic        is_digit, is_end, is_nul, ev_now;
  logic [9:0]  prod;
  logic [5:0]  fed_num, feed_num;
  logic        feed_seen, feed_closed;
  logic [5:0]  new_len;
  logic [1:0]  sh;
  logic [11:0] tone;
  logic [7:0]  lc;

  always_comb begin
    is_nul   = (song_char == CH_NUL);
    is_end   = is_nul || (song_char == CH_SPACE);
    is_digit = (song_char >= CH_ZERO) && (song_char <= CH_NINE);
    lc       = ((song_char >= CH_UP_A) && (song_char <= CH_UP_Z)) ?
               song_char + CASE_OFS : song_char;

    // saturating decimal accumulate
    prod    = {num, 3'b000} + {3'b000, num, 1'b0} + {6'd0, song_char[3:0]};
    fed_num = (prod > {4'd0, NUM_MAX}) ? NUM_MAX : prod[5:0];

    feed_num    = num;
    feed_seen   = seen;
    feed_closed = closed;
    if (!closed) begin
      if (is_digit) begin
        feed_num  = fed_num;
        feed_seen = 1'b1;
      end else begin
        feed_closed = 1'b1;
      end
    end

    new_len = (seen && (num >= 6'd1) && (num <= LEN_NUM_MAX)) ? len_of(num) : len;
    sh      = ((oct >= 3'd1) && (oct <= OCT_MAX)) ? 2'(oct - 3'd1) : 2'd0;
    tone    = {3'b000, pitch_of(note_idx)} << sh;

    ev_now = is_end && ((mode == MODE_LETTER) || (mode == MODE_NOTE) ||
                        (mode == MODE_REST));

    mode_next     = mode;
    note_idx_next = note_idx;
    num_next      = num;
    seen_next     = seen;
    closed_next   = closed;
    oct_next      = oct;
    len_next      = len;

    if (is_end) begin
      if (ev_now) len_next = new_len;
      if ((mode == MODE_OCT) && seen && (num >= 6'd1) && (num <= {3'd0, OCT_MAX}))
        oct_next = num[2:0];
      mode_next = MODE_IDLE;
      if (is_nul) begin
        oct_next = OCT_RESET;
        len_next = LEN_WRAP;
      end
    end else begin
      unique case (mode)
        MODE_IDLE: begin
          num_next    = '0;
          seen_next   = 1'b0;
          closed_next = 1'b0;
          mode_next   = MODE_LETTER;
          unique case (lc)
            CH_C: note_idx_next = IDX_C;
            CH_D: note_idx_next = IDX_D;
            CH_E: note_idx_next = IDX_E;
            CH_F: note_idx_next = IDX_F;
            CH_G: note_idx_next = IDX_G;
            CH_A: note_idx_next = IDX_A;
            CH_B: note_idx_next = IDX_B;
            CH_R: mode_next = MODE_REST;
            CH_O: mode_next = MODE_OCT;
            default: mode_next = MODE_SKIP;
          endcase
        end
        MODE_LETTER: begin
          mode_next = MODE_NOTE;
          if (song_char == CH_SHARP) begin
            // sharp of b stays b
            if (note_idx < IDX_B) note_idx_next = note_idx + 4'd1;
          end else begin
            num_next    = feed_num;
            seen_next   = feed_seen;
            closed_next = feed_closed;
          end
        end
        MODE_NOTE, MODE_REST, MODE_OCT: begin
          num_next    = feed_num;
          seen_next   = feed_seen;
          closed_next = feed_closed;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      note_idx  <= '0;
      num       <= '0;
      seen      <= 1'b0;
      closed    <= 1'b0;
      oct       <= OCT_RESET;
      len       <= LEN_RESET;
      wrap_pend <= 1'b0;
    end else if (cmd.load) begin
      mode      <= mode_next;
      note_idx  <= note_idx_next;
      num       <= num_next;
      seen      <= seen_next;
      closed    <= closed_next;
      oct       <= oct_next;
      len       <= len_next;
      wrap_pend <= is_nul;
    end
  end

  // event result, held until shown
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ev_sil  <= (mode == MODE_REST);
      ev_tone <= (mode == MODE_REST) ? 12'd0 : tone;
      ev_len  <= new_len;
    end
  end

  assign status.ev_now    = ev_now;
  assign status.nul_now   = is_nul;
  assign status.wrap_pend = wrap_pend;

  assign tone_hz      = cmd.show_wrap ? 12'd0    : ev_tone;
  assign length_ticks = cmd.show_wrap ? LEN_WRAP : ev_len;
  assign silent       = cmd.show_wrap ? 1'b1     : ev_sil;
  assign song_wrapped = cmd.show_wrap;

endmodule

@@ sv/nss_controller.sv @@
module nss_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 char_valid,
  output logic                 char_ready,
  output logic                 note_valid,
  input  logic                 note_ready,
  output logic                 last_of_run,
  input  nss_pkg::nss_status_t status,
  output nss_pkg::nss_cmd_t    cmd
);
  import nss_pkg::*;

  ctrl_state_t state, state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (char_valid) begin
          if (status.ev_now)       state_next = ST_EV;
          else if (status.nul_now) state_next = ST_WRAP;
        end
      end
      ST_EV: begin
        if (note_ready) state_next = status.wrap_pend ? ST_WRAP : ST_IDLE;
      end
      ST_WRAP: begin
        if (note_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  assign char_ready    = (state == ST_IDLE);
  assign note_valid    = (state == ST_EV) || (state == ST_WRAP);
  assign last_of_run   = (state == ST_WRAP) || ((state == ST_EV) && !status.wrap_pend);
  assign cmd.load      = char_valid && (state == ST_IDLE);
  assign cmd.show_wrap = (state == ST_WRAP);

endmodule

@@ sv/nss_checker.sv @@
`include "note_string_sequencer_assert.svh"

module nss_checker (
  input logic        clk,
  input logic        rst,
  input logic        char_valid,
  input logic        char_ready,
  input logic [7:0]  song_char,
  input logic        note_valid,
  input logic        note_ready,
  input logic [11:0] tone_hz,
  input logic [5:0]  length_ticks,
  input logic        silent,
  input logic        song_wrapped,
  input logic        last_of_run
);
  import nss_pkg::*;

  // stalled result holds
  `NSS_ASSERT_NEXT(a_hold, note_valid && !note_ready, note_valid && $stable(tone_hz) && $stable(length_ticks) && $stable(song_wrapped))

  // one item at a time
  `NSS_ASSERT_NOW(a_excl, note_valid, !char_ready)

  // end of song always answers next cycle
  `NSS_ASSERT_NEXT(a_nul, char_valid && char_ready && (song_char == CH_NUL), note_valid)

  // wrap result shape
  `NSS_ASSERT_NOW(a_wrap, note_valid && song_wrapped, silent && last_of_run && (tone_hz == 12'd0) && (length_ticks == LEN_WRAP))

  // rests carry no tone
  `NSS_ASSERT_NOW(a_sil, note_valid && silent, tone_hz == 12'd0)

endmodule

bind note_string_sequencer nss_checker u_nss_checker (.*);
